>>> sv/lssa_pkg.sv
package lssa_pkg;

  localparam int LED_COUNT = 32;

  localparam int PIX_W  = 6;
  localparam int COL_W  = 8;
  localparam int TIME_W = 32;
  localparam int STEP_W = 10;
  localparam int PER_W  = 14;
  localparam int PROG_W = 8;
  localparam int PC_W   = 7;
  localparam int LIT_W  = 7;
  localparam int DIV_W  = 17;
  localparam int MULB_W = 15;
  localparam int PROD_W = COL_W + MULB_W;
  localparam int LITP_W = 26;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 24;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int PCT_SHIFT = 19;

  localparam logic [PC_W-1:0]   PROG_MAX  = PC_W'(100);
  localparam logic [LITP_W-1:0] PCT_SCALE = LITP_W'(LED_COUNT * 5243);
  localparam logic [PIX_W-1:0]  LAST_PIX  = PIX_W'(LED_COUNT - 1);
  localparam logic [COL_W-1:0]  COL_MAX   = '1;

  typedef enum logic [2:0] {
    REG_FILL_STEP  = 3'd0,
    REG_EMPTY_STEP = 3'd1,
    REG_BLINK      = 3'd2,
    REG_PEAK_RED   = 3'd3,
    REG_ORANGE_RED = 3'd4,
    REG_ORANGE_GRN = 3'd5,
    REG_READY_GRN  = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    LOC_IDLE  = 2'd0,
    LOC_RUN   = 2'd1,
    LOC_READY = 2'd2,
    LOC_DONE  = 2'd3
  } loc_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_PH,
    OP_K,
    OP_FADE,
    OP_M,
    OP_RED,
    OP_GRN
  } op_e;

  typedef struct packed {
    logic [STEP_W-1:0] fill_step;
    logic [STEP_W-1:0] empty_step;
    logic [PER_W-1:0]  blink_period;
    logic [COL_W-1:0]  peak_red;
    logic [COL_W-1:0]  orange_red;
    logic [COL_W-1:0]  orange_green;
    logic [COL_W-1:0]  ready_green;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quot;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

endpackage

>>> sv/lssa_div.sv
module lssa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lssa_pkg::div_req_t req_i,
  output lssa_pkg::div_rsp_t rsp_o
);
  import lssa_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] dq_q, dq_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, dq_q[TIME_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dq_d  = {dq_q[TIME_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> sv/lssa_regs.sv
module lssa_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lssa_pkg::ADDR_W-1:0]   paddr,
  input  logic [lssa_pkg::DATA_W-1:0]   pwdata,
  output logic [lssa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lssa_pkg::cfg_t                cfg_o
);
  import lssa_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_FILL_STEP:  cfg_d.fill_step    = pwdata[STEP_W-1:0];
        REG_EMPTY_STEP: cfg_d.empty_step   = pwdata[STEP_W-1:0];
        REG_BLINK:      cfg_d.blink_period = pwdata[PER_W-1:0];
        REG_PEAK_RED:   cfg_d.peak_red     = pwdata[COL_W-1:0];
        REG_ORANGE_RED: cfg_d.orange_red   = pwdata[COL_W-1:0];
        REG_ORANGE_GRN: cfg_d.orange_green = pwdata[COL_W-1:0];
        REG_READY_GRN:  cfg_d.ready_green  = pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILL_STEP:  prdata = DATA_W'(cfg_q.fill_step);
      REG_EMPTY_STEP: prdata = DATA_W'(cfg_q.empty_step);
      REG_BLINK:      prdata = DATA_W'(cfg_q.blink_period);
      REG_PEAK_RED:   prdata = DATA_W'(cfg_q.peak_red);
      REG_ORANGE_RED: prdata = DATA_W'(cfg_q.orange_red);
      REG_ORANGE_GRN: prdata = DATA_W'(cfg_q.orange_green);
      REG_READY_GRN:  prdata = DATA_W'(cfg_q.ready_green);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_step    <= STEP_W'(20);
      cfg_q.empty_step   <= STEP_W'(20);
      cfg_q.blink_period <= PER_W'(500);
      cfg_q.peak_red     <= COL_W'(255);
      cfg_q.orange_red   <= COL_W'(255);
      cfg_q.orange_green <= COL_W'(70);
      cfg_q.ready_green  <= COL_W'(180);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/led_strip_status_animator_top.sv
// Channel   | Direction | Contents
// s_axis    | in        | one frame request: time_ms, estop, loc_state, progress
// m_axis    | out       | LED_COUNT pixel results per request, tlast on the final pixel
// apb       | in        | register writes and reads, byte address 4*index
// One shared restoring divider, one quotient bit per cycle.
// Emergency frame: 3 divisions, gauge frame: 3, other frames: none.
// Then one pixel a cycle is sent while m_axis_tready is high.
// s_axis_tready is high only between frames; m_axis stalls hold the current pixel.
// rst_ni clears the sequencer, the stop tracking and loads the register defaults.
module led_strip_status_animator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] time_ms, [32] estop, [34:33] loc_state, [42:35] progress, [47:43] zero
  input  logic [lssa_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] pixel_index, [13:6] red, [21:14] green, [23:22] zero
  output logic [lssa_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lssa_pkg::ADDR_W-1:0]   paddr,
  input  logic [lssa_pkg::DATA_W-1:0]   pwdata,
  output logic [lssa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lssa_pkg::*;

  cfg_t     cfg;
  div_req_t dreq;
  div_rsp_t drsp;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic              seen_q, seen_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [TIME_W-1:0] e_q, e_d;
  logic              estop_q, estop_d;
  loc_e              ls_q, ls_d;
  logic [DIV_W-1:0]  ph_q, ph_d;
  logic              fill_q, fill_d;
  logic [PIX_W-1:0]  k_q, k_d;
  logic [STEP_W-1:0] r_q, r_d;
  logic [COL_W-1:0]  fade_q, fade_d;
  logic [PER_W-1:0]  m_q, m_d;
  logic [COL_W-1:0]  rr_q, rr_d;
  logic [COL_W-1:0]  gg_q, gg_d;
  logic [LIT_W-1:0]  lit_q, lit_d;
  logic [PIX_W-1:0]  pix_q, pix_d;

  logic [TIME_W-1:0] in_time;
  logic              in_estop;
  loc_e              in_ls;
  logic [PROG_W-1:0] in_prog;
  logic              s_acc, m_acc, last;

  logic [STEP_W-1:0] fs, es;
  logic [PER_W-1:0]  per, half, delta;
  logic [DIV_W-1:0]  ftot, ctot, knum;
  logic              fill_c;
  logic [MULB_W-1:0] hd;
  logic [DIV_W-1:0]  h4;
  logic [COL_W-1:0]  mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [COL_W-1:0]  qsat;
  logic [COL_W-1:0]  pix_red, pix_grn;
  logic [PC_W-1:0]   pc_c;
  logic [LITP_W-1:0] lit_prod;

  lssa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lssa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_time  = s_axis_tdata[31:0];
  assign in_estop = s_axis_tdata[32];
  assign in_ls    = loc_e'(s_axis_tdata[34:33]);
  assign in_prog  = s_axis_tdata[42:35];

  assign s_acc = s_axis_tvalid & s_axis_tready;
  assign m_acc = m_axis_tvalid & m_axis_tready;
  assign last  = pix_q == LAST_PIX;

  assign fs    = (cfg.fill_step == '0) ? STEP_W'(1) : cfg.fill_step;
  assign es    = (cfg.empty_step == '0) ? STEP_W'(1) : cfg.empty_step;
  assign per   = (cfg.blink_period < PER_W'(2)) ? PER_W'(2) : cfg.blink_period;
  assign half  = {1'b0, per[PER_W-1:1]};
  assign delta = (m_q < half) ? m_q : per - m_q;
  assign hd    = MULB_W'(half) + MULB_W'(delta) + MULB_W'({delta, 1'b0});
  assign h4    = DIV_W'({half, 2'b00});

  assign ftot   = DIV_W'(fs * LED_COUNT);
  assign ctot   = DIV_W'(({1'b0, fs} + {1'b0, es}) * LED_COUNT);
  assign fill_c = ph_q < ftot;
  assign knum   = fill_c ? ph_q : ph_q - ftot;

  assign pc_c     = (in_prog > PROG_W'(PROG_MAX)) ? PROG_MAX : in_prog[PC_W-1:0];
  assign lit_prod = LITP_W'(pc_c) * PCT_SCALE;

  // multiplier operands; the product is registered in the divider
  always_comb begin
    unique case (op_q)
      OP_FADE: begin
        mul_a = cfg.peak_red;
        mul_b = fill_q ? MULB_W'(r_q) : MULB_W'(es - r_q);
      end
      OP_RED: begin
        mul_a = cfg.orange_red;
        mul_b = hd;
      end
      OP_GRN: begin
        mul_a = cfg.orange_green;
        mul_b = hd;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    dreq.start = state_q == ST_LAUNCH;
    unique case (op_q)
      OP_PH: begin
        dreq.dividend = e_q;
        dreq.divisor  = ctot;
      end
      OP_K: begin
        dreq.dividend = TIME_W'(knum);
        dreq.divisor  = fill_c ? DIV_W'(fs) : DIV_W'(es);
      end
      OP_FADE: begin
        dreq.dividend = TIME_W'(prod);
        dreq.divisor  = fill_q ? DIV_W'(fs) : DIV_W'(es);
      end
      OP_M: begin
        dreq.dividend = t_q;
        dreq.divisor  = DIV_W'(per);
      end
      OP_RED, OP_GRN: begin
        dreq.dividend = TIME_W'(prod);
        dreq.divisor  = h4;
      end
      default: begin
        dreq.dividend = '0;
        dreq.divisor  = '0;
      end
    endcase
  end

  assign qsat = (drsp.quot[TIME_W-1:COL_W] != '0) ? COL_MAX : drsp.quot[COL_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (in_estop || in_ls == LOC_RUN) ? ST_LAUNCH : ST_OUT;
        end
      end
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT: begin
        if (drsp.done) begin
          state_d = (op_q == OP_FADE || op_q == OP_GRN) ? ST_OUT : ST_LAUNCH;
        end
      end
      ST_OUT: begin
        if (m_axis_tready && last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    m_axis_tvalid = state_q == ST_OUT;
  end

  // datapath registers
  always_comb begin
    op_d    = op_q;
    seen_d  = seen_q;
    start_d = start_q;
    t_d     = t_q;
    e_d     = e_q;
    estop_d = estop_q;
    ls_d    = ls_q;
    ph_d    = ph_q;
    fill_d  = fill_q;
    k_d     = k_q;
    r_d     = r_q;
    fade_d  = fade_q;
    m_d     = m_q;
    rr_d    = rr_q;
    gg_d    = gg_q;
    lit_d   = lit_q;
    pix_d   = pix_q;
    if (s_acc) begin
      t_d     = in_time;
      estop_d = in_estop;
      ls_d    = in_ls;
      lit_d   = lit_prod[PCT_SHIFT +: LIT_W];
      pix_d   = '0;
      e_d     = in_time - start_q;
      op_d    = in_estop ? OP_PH : OP_M;
      if (in_estop) begin
        if (!seen_q) begin
          start_d = in_time;
          e_d     = '0;
        end
        seen_d = 1'b1;
      end else begin
        seen_d = 1'b0;
      end
    end
    if (state_q == ST_WAIT && drsp.done) begin
      unique case (op_q)
        OP_PH: begin
          ph_d = drsp.rem;
          op_d = OP_K;
        end
        OP_K: begin
          k_d    = drsp.quot[PIX_W-1:0];
          r_d    = drsp.rem[STEP_W-1:0];
          fill_d = fill_c;
          op_d   = OP_FADE;
        end
        OP_FADE: fade_d = drsp.quot[COL_W-1:0];
        OP_M: begin
          m_d  = drsp.rem[PER_W-1:0];
          op_d = OP_RED;
        end
        OP_RED: begin
          rr_d = qsat;
          op_d = OP_GRN;
        end
        OP_GRN: gg_d = qsat;
        default: ;
      endcase
    end
    if (m_acc && !last) begin
      pix_d = pix_q + PIX_W'(1);
    end
  end

  always_comb begin
    pix_red = '0;
    pix_grn = '0;
    if (estop_q) begin
      if (pix_q < k_q) begin
        pix_red = fill_q ? cfg.peak_red : '0;
      end else if (pix_q == k_q) begin
        pix_red = fade_q;
      end else begin
        pix_red = fill_q ? '0 : cfg.peak_red;
      end
    end else begin
      unique case (ls_q)
        LOC_RUN: begin
          if (LIT_W'(pix_q) < lit_q) begin
            pix_red = rr_q;
            pix_grn = gg_q;
          end
        end
        LOC_READY: pix_grn = cfg.ready_green;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, pix_grn, pix_red, pix_q};
  assign m_axis_tlast = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_PH;
      seen_q  <= 1'b0;
      start_q <= '0;
      pix_q   <= '0;
      estop_q <= 1'b0;
      ls_q    <= LOC_IDLE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      seen_q  <= seen_d;
      start_q <= start_d;
      pix_q   <= pix_d;
      estop_q <= estop_d;
      ls_q    <= ls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    e_q    <= e_d;
    ph_q   <= ph_d;
    fill_q <= fill_d;
    k_q    <= k_d;
    r_q    <= r_d;
    fade_q <= fade_d;
    m_q    <= m_d;
    rr_q   <= rr_d;
    gg_q   <= gg_d;
    lit_q  <= lit_d;
  end

endmodule
